>>> rtl/pn3d_pkg.sv
// shared types, constants, permutation table and gradient function for the 3-d noise core
package pn3d_pkg;

  localparam int unsigned FRAC_W = 16;
  localparam int unsigned GRAD_W = 19;
  localparam int unsigned COORD_W = FRAC_W + 2;
  localparam int unsigned NUM_CORNERS = 8;

  typedef logic [7:0] cell_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [3:0] hash_t;

  localparam cell_t PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53,
    8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75,
    8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133,
    8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102,
    8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76,
    8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116,
    8'd188, 8'd159, 8'd86, 8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
    8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118,
    8'd126, 8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119,
    8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155,
    8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108,
    8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246,
    8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191,
    8'd179, 8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204,
    8'd176, 8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236,
    8'd205, 8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128,
    8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  localparam hash_t H_X_Z0 = 4'd12;
  localparam hash_t H_X_Z1 = 4'd14;

  function automatic grad_t grad(hash_t h, coord_t x, coord_t y, coord_t z);
    coord_t u;
    coord_t v;
    grad_t  su;
    grad_t  sv;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      v = y;
    end else if (h == H_X_Z0 || h == H_X_Z1) begin
      v = x;
    end else begin
      v = z;
    end
    su = GRAD_W'(u);
    sv = GRAD_W'(v);
    if (h[0]) su = -su;
    if (h[1]) sv = -sv;
    return su + sv;
  endfunction

endpackage

>>> rtl/pn3d_fade.sv
// four-stage fade curve 6t^5-15t^4+10t^3 on a q0.16 fraction
module pn3d_fade import pn3d_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  frac_t t_i,
  output frac_t fade_o
);

  frac_t        t_q;
  logic [31:0]  t2_q;
  logic [31:0]  t2_d;
  logic [47:0]  cube_d, cube_q;
  logic [19:0]  t15;
  logic [35:0]  q_d, q_q;
  logic [51:0]  prod_d, prod_q;
  frac_t        fade_d, fade_q;

  assign t2_d   = t_i * t_i;
  assign cube_d = t2_q * t_q;
  assign t15    = {t_q, 4'b0000} - 20'(t_q);
  assign q_d    = 36'({t2_q, 2'b00}) + 36'({t2_q, 1'b0}) + 36'hA_0000_0000
                - {t15, 16'h0000};
  assign prod_d = cube_q[47:24] * q_q[35:8];
  assign fade_d = (|prod_q[51:48]) ? 16'hFFFF : prod_q[47:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_i;
      t2_q   <= t2_d;
      cube_q <= cube_d;
      q_q    <= q_d;
      prod_q <= prod_d;
      fade_q <= fade_d;
    end
  end

  assign fade_o = fade_q;

endmodule

>>> rtl/pn3d_lerp.sv
// two-stage linear blend a + floor(t*(b-a)/2^16)
module pn3d_lerp import pn3d_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  frac_t t_i,
  input  grad_t a_i,
  input  grad_t b_i,
  output grad_t y_o
);

  localparam int unsigned PROD_W = GRAD_W + 1 + FRAC_W + 1;

  logic signed [GRAD_W:0]     diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-17:0]  shifted;
  grad_t                      a_q;
  grad_t                      y_d, y_q;

  assign diff    = {b_i[GRAD_W-1], b_i} - {a_i[GRAD_W-1], a_i};
  assign prod_d  = $signed({1'b0, t_i}) * diff;
  assign shifted = prod_q[PROD_W-1:16];
  // the blend stays between a and b, so the sum fits the gradient width
  assign y_d     = a_q + grad_t'(shifted[GRAD_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

>>> rtl/perlin_noise_3d_core.sv
// top level: improved 3-d gradient noise core, twelve pipeline stages
// Takes one point per clock in signed fixed point (FRAC_BITS fraction bits) and returns
// (n+1)/2 in unsigned q0.16, saturated. Throughput is one point per cycle while results
// are taken. The whole pipeline advances together and holds when the result register is
// full and not taken; the permutation lookups, the fade multipliers and the blend
// multipliers each occupy their own stages.
module perlin_noise_3d_core import pn3d_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        noise_value_o
);

  localparam int unsigned STAGES = 12;

  logic              en;
  logic [STAGES-1:0] vld_q;
  frac_t             fx_d, fy_d, fz_d;

  cell_t cx1_q, cy1_q, cz1_q;
  frac_t f1_q [3];
  cell_t a2_q, b2_q, cz2_q;
  frac_t f2_q [3];
  cell_t c3_q [4];
  frac_t f3_q [3];
  hash_t h4_q [NUM_CORNERS];
  frac_t f4_q [3];
  grad_t g5_q [NUM_CORNERS];
  frac_t u5, v5, w5;
  frac_t v6_q, v7_q, w6_q, w7_q, w8_q, w9_q;
  grad_t l7 [4];
  grad_t m9 [2];
  grad_t n11;
  logic signed [GRAD_W:0] s_sum;
  logic [15:0] noise_d, noise_q;

  assign en         = !vld_q[STAGES-1] || out_ready_i;
  assign in_ready_o = en;

  if (FRAC_BITS >= FRAC_W) begin : g_frac_down
    assign fx_d = pos_x_i[FRAC_BITS-1 -: FRAC_W];
    assign fy_d = pos_y_i[FRAC_BITS-1 -: FRAC_W];
    assign fz_d = pos_z_i[FRAC_BITS-1 -: FRAC_W];
  end else begin : g_frac_up
    assign fx_d = {pos_x_i[FRAC_BITS-1:0], (FRAC_W-FRAC_BITS)'(0)};
    assign fy_d = {pos_y_i[FRAC_BITS-1:0], (FRAC_W-FRAC_BITS)'(0)};
    assign fz_d = {pos_z_i[FRAC_BITS-1:0], (FRAC_W-FRAC_BITS)'(0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // cell and fraction split
      cx1_q <= pos_x_i[FRAC_BITS +: 8];
      cy1_q <= pos_y_i[FRAC_BITS +: 8];
      cz1_q <= pos_z_i[FRAC_BITS +: 8];
      f1_q  <= '{fx_d, fy_d, fz_d};
      // first hash level
      a2_q  <= PERM[cx1_q] + cy1_q;
      b2_q  <= PERM[cx1_q + 8'd1] + cy1_q;
      cz2_q <= cz1_q;
      f2_q  <= f1_q;
      // second hash level: aa, ba, ab, bb
      c3_q[0] <= PERM[a2_q] + cz2_q;
      c3_q[1] <= PERM[b2_q] + cz2_q;
      c3_q[2] <= PERM[a2_q + 8'd1] + cz2_q;
      c3_q[3] <= PERM[b2_q + 8'd1] + cz2_q;
      f3_q    <= f2_q;
      f4_q    <= f3_q;
      v6_q <= v5;
      v7_q <= v6_q;
      w6_q <= w5;
      w7_q <= w6_q;
      w8_q <= w7_q;
      w9_q <= w8_q;
      noise_q <= noise_d;
    end
  end

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    coord_t gx, gy, gz;
    assign gx = k[0] ? {2'b11, f4_q[0]} : {2'b00, f4_q[0]};
    assign gy = k[1] ? {2'b11, f4_q[1]} : {2'b00, f4_q[1]};
    assign gz = k[2] ? {2'b11, f4_q[2]} : {2'b00, f4_q[2]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        h4_q[k] <= PERM[c3_q[k%4] + 8'(k/4)][3:0];
        g5_q[k] <= grad(h4_q[k], gx, gy, gz);
      end
    end
  end

  pn3d_fade u_fade_x (.clk_i, .en_i(en), .t_i(f1_q[0]), .fade_o(u5));
  pn3d_fade u_fade_y (.clk_i, .en_i(en), .t_i(f1_q[1]), .fade_o(v5));
  pn3d_fade u_fade_z (.clk_i, .en_i(en), .t_i(f1_q[2]), .fade_o(w5));

  for (genvar i = 0; i < 4; i++) begin : g_lerp_x
    pn3d_lerp u_lerp (
      .clk_i, .en_i(en), .t_i(u5), .a_i(g5_q[2*i]), .b_i(g5_q[2*i+1]), .y_o(l7[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_lerp_y
    pn3d_lerp u_lerp (
      .clk_i, .en_i(en), .t_i(v7_q), .a_i(l7[2*i]), .b_i(l7[2*i+1]), .y_o(m9[i])
    );
  end

  pn3d_lerp u_lerp_z (
    .clk_i, .en_i(en), .t_i(w9_q), .a_i(m9[0]), .b_i(m9[1]), .y_o(n11)
  );

  // remap to (n+1)/2 with saturation
  assign s_sum = {n11[GRAD_W-1], n11} + (GRAD_W+1)'(32'd65536);
  always_comb begin
    if (s_sum[GRAD_W]) begin
      noise_d = '0;
    end else if (|s_sum[GRAD_W-1:17]) begin
      noise_d = 16'hFFFF;
    end else begin
      noise_d = s_sum[16:1];
    end
  end

  assign out_valid_o   = vld_q[STAGES-1];
  assign noise_value_o = noise_q;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && in_valid_i |=> vld_q[0])
    else $error("accepted transaction not captured in first stage");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[STAGES-1:1] == $past(vld_q[STAGES-2:0]))
    else $error("valid bits did not advance one stage");

endmodule
